FILE: sv/xbfd_pkg.sv
// Shared types and constants of the x86 branch filter decoder.
`default_nettype none

package xbfd_pkg;

  // Payload of one input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  // Payload of one output beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       out_stream_end;
  } out_item_t;

  // Window sizes: one instruction is an opcode plus a 32-bit operand.
  localparam int WinLen    = 5;
  localparam int PendDepth = 4;

  // Opcodes and operand top bytes that mark a rewritable branch.
  localparam logic [7:0] OpCall  = 8'hE8;
  localparam logic [7:0] OpJump  = 8'hE9;
  localparam logic [7:0] TopZero = 8'h00;
  localparam logic [7:0] TopOnes = 8'hFF;

  // Instruction length, added to the offset of the opcode.
  localparam logic [31:0] InsnLen = 32'd5;

endpackage

`default_nettype wire

FILE: sv/xbfd_in_if.sv
// Input channel of the x86 branch filter decoder.
`default_nettype none

interface xbfd_in_if;
  import xbfd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/xbfd_out_if.sv
// Output channel of the x86 branch filter decoder.
`default_nettype none

interface xbfd_out_if;
  import xbfd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/x86_branch_filter_decoder.sv
// Top level of the x86 branch filter decoder: window, operand rewrite and output buffer.
`default_nettype none

// Inverse x86 call/jump filter. Bytes enter on din, one per beat, and are
// registered; from the input register one pass of logic builds the five-byte
// window, rewrites the operand of an E8/E9 branch and loads every byte that
// the beat releases into a five-entry output buffer, which drains on dout one
// byte per cycle while dout is ready. A beat that releases no byte never
// waits, so the block takes one byte per cycle while dout keeps up; a beat
// that releases bytes waits in the input register until the buffer holds at
// most its last byte being taken. A rewritten branch releases five bytes at
// once; the four beats that refill the window release none and cover its
// drain, so din stalls only when dout holds off or an end mark arrives while
// the buffer is still draining. A released byte passes the input register and
// then the output buffer on its way to dout. No clearing pass follows reset.
module x86_branch_filter_decoder (
  input  logic          clk,
  input  logic          rst,
  xbfd_in_if.sink       din,
  xbfd_out_if.source    dout
);
  import xbfd_pkg::*;

  // Input register.
  logic     in_vld;
  in_item_t in_data;

  // Window state.
  logic [7:0]  pend [PendDepth];
  logic [2:0]  pend_cnt;
  logic [31:0] head_off;

  // Output buffer, oldest byte in entry zero.
  logic [7:0] obuf [WinLen];
  logic [2:0] orem;
  logic       olast;

  // Combinational window pass.
  logic [2:0]  held;
  logic        full;
  logic        match;
  logic [7:0]  win [WinLen];
  logic [7:0]  res [WinLen];
  logic [31:0] src;
  logic [31:0] dst;
  logic [2:0]  nres;
  logic [2:0]  pend_cnt_next;
  logic [31:0] head_off_next;
  logic [7:0]  pend_next [PendDepth];
  logic        obuf_free;
  logic        retire;
  logic        load;
  logic        pop;

  // Build the window: held bytes first, then the new byte at the fill point.
  always_comb begin
    held = (pend_cnt > 3'(PendDepth)) ? 3'(PendDepth) : pend_cnt;
    for (int i = 0; i < PendDepth; i++) begin
      win[i] = (3'(i) == held) ? in_data.data_byte : pend[i];
    end
    win[PendDepth] = in_data.data_byte;
    full  = (held == 3'(PendDepth));
    match = full && (win[0] == OpCall || win[0] == OpJump) &&
            (win[4] == TopZero || win[4] == TopOnes);
    src = {win[4], win[3], win[2], win[1]};
    dst = src - (head_off + InsnLen);
  end

  // Released bytes and the next window state.
  always_comb begin
    res[0] = win[0];
    res[1] = match ? dst[7:0]   : win[1];
    res[2] = match ? dst[15:8]  : win[2];
    res[3] = match ? dst[23:16] : win[3];
    res[4] = match ? dst[31:24] : win[4];

    if (full) begin
      nres = (match || in_data.stream_end) ? 3'(WinLen) : 3'd1;
    end else begin
      nres = in_data.stream_end ? (held + 3'd1) : 3'd0;
    end

    // A non-branch full window drops its oldest byte; one that is not full just grows.
    for (int i = 0; i < PendDepth; i++) begin
      pend_next[i] = full ? win[i + 1] : win[i];
    end

    if (in_data.stream_end || match) begin
      pend_cnt_next = 3'd0;
    end else if (full) begin
      pend_cnt_next = 3'(PendDepth);
    end else begin
      pend_cnt_next = held + 3'd1;
    end

    if (in_data.stream_end) begin
      head_off_next = 32'd0;
    end else if (match) begin
      head_off_next = head_off + InsnLen;
    end else if (full) begin
      head_off_next = head_off + 32'd1;
    end else begin
      head_off_next = head_off;
    end
  end

  // Handshake control.
  assign pop       = dout.valid && dout.ready;
  assign obuf_free = (orem == 3'd0) || (orem == 3'd1 && dout.ready);
  assign retire    = in_vld && (nres == 3'd0 || obuf_free);
  assign load      = retire && (nres != 3'd0);
  assign din.ready = !in_vld || retire;

  // Output beat comes from the head of the buffer.
  assign dout.valid               = (orem != 3'd0);
  assign dout.data.out_byte       = obuf[0];
  assign dout.data.run_end        = (orem == 3'd1);
  assign dout.data.out_stream_end = (orem == 3'd1) && olast;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      pend_cnt <= 3'd0;
      head_off <= 32'd0;
      orem     <= 3'd0;
    end else begin
      if (din.valid && din.ready) begin
        in_vld <= 1'b1;
      end else if (retire) begin
        in_vld <= 1'b0;
      end
      if (retire) begin
        pend_cnt <= pend_cnt_next;
        head_off <= head_off_next;
      end
      if (load) begin
        orem <= nres;
      end else if (pop) begin
        orem <= orem - 3'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_data <= din.data;
    end
    if (retire) begin
      for (int i = 0; i < PendDepth; i++) begin
        pend[i] <= pend_next[i];
      end
    end
    if (load) begin
      for (int i = 0; i < WinLen; i++) begin
        obuf[i] <= res[i];
      end
      olast <= in_data.stream_end;
    end else if (pop) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        obuf[i] <= obuf[i + 1];
      end
    end
  end

`ifndef SYNTHESIS
  // The buffer never holds more than one window.
  a_orem_bound: assert property (@(posedge clk) disable iff (rst)
    orem <= 3'(WinLen))
    else $error("output buffer count out of range");

  // The window never holds more than four pending bytes.
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= 3'(PendDepth))
    else $error("pending byte count out of range");

  // A beat that releases bytes shows on dout in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> dout.valid)
    else $error("loaded bytes not presented");

  // A beat held in the input register keeps its payload.
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    in_vld && !retire |=> in_vld && $stable(in_data))
    else $error("held input beat changed");
`endif

endmodule

`default_nettype wire

FILE: bench/x86_branch_filter_decoder_tb.sv
// Self-checking testbench of the x86 branch filter decoder.
`default_nettype none

module x86_branch_filter_decoder_tb;
  import xbfd_pkg::*;

  // Run shape.
  localparam int TotalItems   = 420;
  localparam int DirRows      = 25;
  localparam int HoldAtBeat   = 150;
  localparam int HoldCycles   = 40;
  localparam int IdleFreeFrom = 370;
  localparam int QuietLimit   = 500;
  localparam int DrainCycles  = 8;
  localparam int PrintLimit   = 50;

  // Directed rows either carry their expected bytes or defer to the decoder model.
  localparam logic Typed = 1'b1;
  localparam logic Model = 1'b0;

  typedef struct packed {
    in_item_t         beat;
    logic             typed_ok;
    logic [2:0]       typed_n;
    logic [4:0][7:0]  typed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  xbfd_in_if  din ();
  xbfd_out_if dout ();

  x86_branch_filter_decoder i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Directed stimulus: extremes, both opcodes, both top bytes and every end case.
  dir_row_t dir_rows [DirRows] = '{
    // Smallest stream: one byte with the end mark.
    {8'h00, 1'b1, Typed, 3'd1, 40'h00_0000_0000},
    // Call at offset zero whose operand equals the instruction length.
    {8'hE8, 1'b0, Typed, 3'd0, 40'h0},
    {8'h05, 1'b0, Typed, 3'd0, 40'h0},
    {8'h00, 1'b0, Typed, 3'd0, 40'h0},
    {8'h00, 1'b0, Typed, 3'd0, 40'h0},
    {8'h00, 1'b1, Typed, 3'd5, 40'h00_0000_00E8},
    // Jump with an all-ones top byte.
    {8'hE9, 1'b0, Model, 3'd0, 40'h0},
    {8'h00, 1'b0, Model, 3'd0, 40'h0},
    {8'h00, 1'b0, Model, 3'd0, 40'h0},
    {8'h00, 1'b0, Model, 3'd0, 40'h0},
    {8'hFF, 1'b1, Model, 3'd0, 40'h0},
    // Opcode whose top byte does not qualify, then an end mark with four bytes held.
    {8'hE8, 1'b0, Model, 3'd0, 40'h0},
    {8'h11, 1'b0, Model, 3'd0, 40'h0},
    {8'h22, 1'b0, Model, 3'd0, 40'h0},
    {8'h33, 1'b0, Model, 3'd0, 40'h0},
    {8'h44, 1'b0, Model, 3'd0, 40'h0},
    {8'h55, 1'b1, Model, 3'd0, 40'h0},
    // End mark on a partial window passes the held bytes through.
    {8'hE8, 1'b0, Typed, 3'd0, 40'h0},
    {8'h01, 1'b1, Typed, 3'd2, 40'h00_0000_01E8},
    // Jump at an odd offset, completed by the end-marked byte.
    {8'h00, 1'b0, Model, 3'd0, 40'h0},
    {8'hE9, 1'b0, Model, 3'd0, 40'h0},
    {8'h10, 1'b0, Model, 3'd0, 40'h0},
    {8'h20, 1'b0, Model, 3'd0, 40'h0},
    {8'h30, 1'b0, Model, 3'd0, 40'h0},
    {8'hFF, 1'b1, Model, 3'd0, 40'h0}
  };

  // Decoder model state.
  logic [7:0]  held_bytes [PendDepth];
  int unsigned held_cnt = 0;
  logic [31:0] opc_offset = '0;

  // Bytes released by the current beat, and all bytes still owed by the block.
  out_item_t beat_bytes [$];
  out_item_t expected_bytes [$];
  in_item_t  stream_beats [$];

  // Expectations typed into the directed row now on the bus.
  logic            cur_typed_ok = 1'b0;
  logic [2:0]      cur_typed_n  = '0;
  logic [4:0][7:0] cur_typed    = '0;

  logic hold_req = 1'b0;
  logic no_idle  = 1'b0;

  int beats_in   = 0;
  int beats_sent = 0;
  int bytes_out  = 0;
  int rewrites   = 0;
  int streams    = 0;
  int mismatches = 0;
  int quiet      = 0;

  function automatic void release_byte(input logic [7:0] b);
    out_item_t o;
    o = '0;
    o.out_byte = b;
    beat_bytes.push_back(o);
  endfunction

  // Model of one input beat: fills beat_bytes with the bytes it releases.
  function automatic void decode_beat(input in_item_t beat);
    logic [7:0]  win [WinLen];
    int unsigned cnt;
    logic [31:0] operand;
    logic [31:0] rebased;
    beat_bytes.delete();
    cnt = held_cnt;
    for (int i = 0; i < cnt; i++) win[i] = held_bytes[i];
    win[cnt] = beat.data_byte;
    cnt++;

    // Full window: rewrite a qualifying branch or slide by one byte.
    if (cnt == WinLen) begin
      if ((win[0] == OpCall || win[0] == OpJump) &&
          (win[4] == TopZero || win[4] == TopOnes)) begin
        operand = {win[4], win[3], win[2], win[1]};
        rebased = operand - (opc_offset + InsnLen);
        {win[4], win[3], win[2], win[1]} = rebased;
        for (int i = 0; i < WinLen; i++) release_byte(win[i]);
        cnt = 0;
        opc_offset += InsnLen;
        rewrites++;
      end else begin
        release_byte(win[0]);
        for (int i = 0; i < PendDepth; i++) win[i] = win[i + 1];
        cnt = PendDepth;
        opc_offset += 32'd1;
      end
    end

    // End of stream flushes the window and restarts the offset.
    if (beat.stream_end) begin
      for (int i = 0; i < cnt; i++) release_byte(win[i]);
      cnt = 0;
      opc_offset = '0;
      if (beat_bytes.size() > 0) beat_bytes[beat_bytes.size() - 1].out_stream_end = 1'b1;
    end

    for (int i = 0; i < cnt; i++) held_bytes[i] = win[i];
    held_cnt = cnt;
    if (beat_bytes.size() > 0) beat_bytes[beat_bytes.size() - 1].run_end = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    // Only the first few are printed so a broken block cannot flood the log.
    if (mismatches < PrintLimit)
      $display("MISMATCH %s at output byte %0d: got %h, want %h", what, bytes_out, got, want);
    mismatches++;
  endtask

  // Check output beats against the oldest expectation and predict input beats.
  always @(posedge clk) begin : scoreboard
    out_item_t got;
    out_item_t want;
    if (!rst) begin
      if (dout.valid && dout.ready) begin
        got = dout.data;
        if (expected_bytes.size() == 0) begin
          report_mismatch("byte with nothing expected", got.out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
          if (got.run_end !== want.run_end)
            report_mismatch("run_end", 8'(got.run_end), 8'(want.run_end));
          if (got.out_stream_end !== want.out_stream_end)
            report_mismatch("out_stream_end", 8'(got.out_stream_end), 8'(want.out_stream_end));
        end
        bytes_out++;
      end
      if (din.valid && din.ready) begin
        decode_beat(din.data);
        // A typed row replaces the modeled bytes; the model still advances.
        if (cur_typed_ok) begin
          beat_bytes.delete();
          for (int k = 0; k < cur_typed_n; k++) release_byte(cur_typed[k]);
          if (beat_bytes.size() > 0) begin
            beat_bytes[beat_bytes.size() - 1].run_end = 1'b1;
            beat_bytes[beat_bytes.size() - 1].out_stream_end = din.data.stream_end;
          end
        end
        foreach (beat_bytes[k]) expected_bytes.push_back(beat_bytes[k]);
        beats_in++;
        if (beats_in == HoldAtBeat) hold_req <= 1'b1;
        if (beats_in >= IdleFreeFrom) no_idle <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QuietLimit) begin
      $display("Timeout after %0d quiet cycles, %0d bytes still expected",
               quiet, expected_bytes.size());
      $display("x86_branch_filter_decoder_tb failed");
      $finish;
    end
  end

  // Output side: random short stalls, one long hold-off, none near the end.
  initial begin : receiver
    int stall_left;
    int hold_left;
    bit hold_used;
    stall_left = 0;
    hold_left  = 0;
    hold_used  = 1'b0;
    dout.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_left = HoldCycles;
        hold_used = 1'b1;
      end
      if (rst) begin
        dout.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        dout.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        dout.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        dout.ready <= 1'b0;
      end else begin
        dout.ready <= 1'b1;
      end
    end
  end

  // Offers one beat at a falling edge and returns at the falling edge after it is taken.
  task automatic send_beat(input in_item_t beat, input logic typed_ok,
                           input logic [2:0] typed_n, input logic [4:0][7:0] typed);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      din.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_typed_ok = typed_ok;
    cur_typed_n  = typed_n;
    cur_typed    = typed;
    din.valid <= 1'b1;
    din.data  <= beat;
    do @(posedge clk); while (!din.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  // One random stream: mostly branch-shaped runs with random content, some noise.
  function automatic void build_stream();
    int       len;
    in_item_t it;
    stream_beats.delete();
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
    // The last stream is cut so the run ends exactly at the item count.
    if (len > TotalItems - beats_sent) len = TotalItems - beats_sent;
    it = '0;
    while (stream_beats.size() < len) begin
      if ($urandom_range(0, 9) < 4) begin
        // Opcode, three operand bytes and a top byte, each mostly well formed.
        if ($urandom_range(0, 9) == 0) it.data_byte = 8'($urandom);
        else it.data_byte = $urandom_range(0, 1) ? OpCall : OpJump;
        stream_beats.push_back(it);
        repeat (3) begin
          it.data_byte = 8'($urandom);
          stream_beats.push_back(it);
        end
        if ($urandom_range(0, 4) == 0) it.data_byte = 8'($urandom);
        else it.data_byte = $urandom_range(0, 1) ? TopOnes : TopZero;
        stream_beats.push_back(it);
      end else begin
        case ($urandom_range(0, 7))
          0: it.data_byte = $urandom_range(0, 1) ? OpCall : OpJump;
          1: it.data_byte = $urandom_range(0, 1) ? TopOnes : TopZero;
          default: it.data_byte = 8'($urandom);
        endcase
        stream_beats.push_back(it);
      end
    end
    // A branch may be cut short by the end of the stream.
    while (stream_beats.size() > len) void'(stream_beats.pop_back());
    stream_beats[len - 1].stream_end = 1'b1;
  endfunction

  initial begin
    din.valid = 1'b0;
    din.data  = '0;
    rst       = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].beat, dir_rows[i].typed_ok, dir_rows[i].typed_n,
                dir_rows[i].typed);

    // Pause the input until every owed byte has come out.
    din.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    @(negedge clk);

    while (beats_sent < TotalItems) begin
      build_stream();
      foreach (stream_beats[i]) send_beat(stream_beats[i], Model, 3'd0, 40'h0);
      streams++;
    end
    din.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d beats (%0d random streams), %0d branch operands rewritten",
             beats_in, streams, rewrites);
    $display("Checked %0d output bytes, %0d mismatches", bytes_out, mismatches);
    if (mismatches == 0)
      $display("x86_branch_filter_decoder_tb passed");
    else
      $display("x86_branch_filter_decoder_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
